// ----- rtl/cau_pkg.sv -----
// Shared types, opcode and class codes for the complex arithmetic unit.
// Used by every module of the block; depends on nothing else.
package cau_pkg;

    localparam int FIELD_BITS  = 32;
    localparam int PROD_W      = 64;
    localparam int SUM_W       = 65;
    localparam int DEN_W       = 64;
    localparam int DIV_STEPS   = 32;
    localparam int QUEUE_DEPTH = 4;

    // Opcodes as they arrive on the command field.
    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_SUB  = 4'd1;
    localparam logic [3:0] CMD_MUL  = 4'd2;
    localparam logic [3:0] CMD_DIV  = 4'd3;
    localparam logic [3:0] CMD_RADD = 4'd4;
    localparam logic [3:0] CMD_RSUB = 4'd5;
    localparam logic [3:0] CMD_RMUL = 4'd6;
    localparam logic [3:0] CMD_RDIV = 4'd7;
    localparam logic [3:0] CMD_NEG  = 4'd8;
    localparam logic [3:0] CMD_EQ   = 4'd9;
    localparam logic [3:0] CMD_NE   = 4'd10;
    localparam logic [3:0] CMD_LT   = 4'd11;
    localparam logic [3:0] CMD_GT   = 4'd12;

    // Operation classes assigned by the front end.
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_LIN  = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_DIV  = 3'd3;
    localparam logic [2:0] KIND_CMP  = 3'd4;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [2:0]         kind;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } item_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sat_t;

    typedef struct packed {
        logic [DEN_W-1:0]      rem;
        logic [DIV_STEPS-1:0]  quo;
        logic [DIV_STEPS-1:0]  low;
    } lane_t;

    typedef struct packed {
        logic               is_div;
        logic               dz;
        logic               cmp;
        logic               neg_r;
        logic               neg_i;
        logic               ovf_r;
        logic               ovf_i;
        logic               sat;
        logic signed [31:0] res_r;
        logic signed [31:0] res_i;
    } tag_t;

endpackage

// ----- rtl/cau_front.sv -----
// Front end: accepts input words, narrows operands and classifies the opcode.
// Depends on cau_pkg.
module cau_front #(
    parameter int WORD_BITS = 32
) (
    input  logic               push,
    input  logic               full,
    input  logic [3:0]         cmd,
    input  logic signed [31:0] a_real,
    input  logic signed [31:0] a_imag,
    input  logic signed [31:0] b_real,
    input  logic signed [31:0] b_imag,
    output logic               wr,
    output cau_pkg::item_t     item
);

    localparam int DATA_BITS = (WORD_BITS < cau_pkg::FIELD_BITS) ? WORD_BITS
                                                                 : cau_pkg::FIELD_BITS;
    localparam int EXT = cau_pkg::FIELD_BITS - DATA_BITS;

    // Keep the low DATA_BITS bits of a field and sign-extend them.
    function automatic logic signed [31:0] narrow(input logic [31:0] raw);
        logic [31:0] up;
        begin
            up = raw << EXT;
            return $signed(up) >>> EXT;
        end
    endfunction

    assign wr = push && !full;

    // Narrow the operands and classify the opcode for the back end.
    always_comb
    begin
        item.cmd = cmd;
        item.ar  = narrow(a_real);
        item.ai  = narrow(a_imag);
        item.br  = narrow(b_real);
        item.bi  = narrow(b_imag);
        unique case (cmd)
            cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_RADD,
            cau_pkg::CMD_RSUB, cau_pkg::CMD_NEG:  item.kind = cau_pkg::KIND_LIN;
            cau_pkg::CMD_MUL, cau_pkg::CMD_RMUL:  item.kind = cau_pkg::KIND_MUL;
            cau_pkg::CMD_DIV, cau_pkg::CMD_RDIV:  item.kind = cau_pkg::KIND_DIV;
            cau_pkg::CMD_EQ, cau_pkg::CMD_NE,
            cau_pkg::CMD_LT, cau_pkg::CMD_GT:     item.kind = cau_pkg::KIND_CMP;
            default:                              item.kind = cau_pkg::KIND_NONE;
        endcase
    end

endmodule

// ----- rtl/cau_queue.sv -----
// Short queue of classified words between the front and back ends.
// Depends on cau_pkg.
module cau_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  cau_pkg::item_t wdata,
    input  logic           rd,
    output logic           valid,
    output cau_pkg::item_t rdata,
    output logic           full
);

    localparam int AW = $clog2(cau_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(cau_pkg::QUEUE_DEPTH + 1);

    cau_pkg::item_t slot_reg [cau_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wp_reg, wp_next;
    logic [AW-1:0]  rp_reg, rp_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CW'(cau_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = slot_reg[rp_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wp_next    = wr ? wp_reg + AW'(1) : wp_reg;
        rp_next    = rd ? rp_reg + AW'(1) : rp_reg;
        count_next = count_reg + CW'(wr) - CW'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/cau_back.sv -----
// Back end: multiply, combine, pipelined restoring division, saturation and
// the output register. Depends on cau_pkg.
module cau_back #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cau_pkg::item_t     q_item,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] res_real,
    output logic signed [31:0] res_imag,
    output logic               compare_true,
    output logic               divide_by_zero,
    output logic               saturated
);

    localparam int DATA_BITS = (WORD_BITS < cau_pkg::FIELD_BITS) ? WORD_BITS
                                                                 : cau_pkg::FIELD_BITS;
    localparam int SW    = cau_pkg::SUM_W;
    localparam int DW    = cau_pkg::DEN_W;
    localparam int NS    = cau_pkg::DIV_STEPS;
    localparam int NUM_W = SW + FRAC_BITS;
    localparam logic signed [SW-1:0] MAX_V = (SW'(1) <<< (DATA_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MIN_V = -MAX_V - SW'(1);

    // Clamp a wide value to the data range.
    function automatic cau_pkg::sat_t clamp(input logic signed [SW-1:0] v);
        cau_pkg::sat_t r;
        begin
            if (v > MAX_V)
            begin
                r.sat = 1'b1;
                r.val = MAX_V[31:0];
            end
            else if (v < MIN_V)
            begin
                r.sat = 1'b1;
                r.val = MIN_V[31:0];
            end
            else
            begin
                r.sat = 1'b0;
                r.val = v[31:0];
            end
            return r;
        end
    endfunction

    // One restoring division step: one quotient bit.
    function automatic cau_pkg::lane_t div_step(input cau_pkg::lane_t x,
                                                input logic [DW-1:0] den);
        logic [DW:0]    trial;
        logic           ge;
        cau_pkg::lane_t r;
        begin
            trial = {x.rem, x.low[NS-1]};
            ge    = (trial >= {1'b0, den});
            r.rem = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
            r.quo = {x.quo[NS-2:0], ge};
            r.low = {x.low[NS-2:0], 1'b0};
            return r;
        end
    endfunction

    logic adv;
    logic out_valid_reg;

    // The whole pipeline moves while the output register is free or is read.
    assign adv   = !out_valid_reg || pop;
    assign q_pop = adv && q_valid;
    assign empty = !out_valid_reg;

    // Stage 1: operand multiplies and linear results.
    logic signed [31:0]           ma [6];
    logic signed [31:0]           mb [6];
    logic signed [SW-1:0]         lin_t, lin_u, lin_d;
    logic                         eq_cmp;
    logic                         s1_valid_reg;
    logic [3:0]                   s1_cmd_reg;
    logic [2:0]                   s1_kind_reg;
    logic signed [cau_pkg::PROD_W-1:0] s1_p_reg [6];
    logic signed [SW-1:0]         s1_t_reg, s1_u_reg, s1_d_reg;
    logic                         s1_cmp_reg;

    always_comb
    begin
        ma[0] = q_item.ar;
        ma[1] = q_item.ai;
        ma[2] = q_item.ar;
        ma[3] = q_item.ai;
        ma[4] = q_item.br;
        ma[5] = q_item.bi;
        mb[0] = (q_item.kind == cau_pkg::KIND_CMP) ? q_item.ar : q_item.br;
        mb[1] = (q_item.kind == cau_pkg::KIND_CMP) ? q_item.ai : q_item.bi;
        mb[2] = q_item.bi;
        mb[3] = q_item.br;
        mb[4] = q_item.br;
        mb[5] = q_item.bi;
        lin_t  = '0;
        lin_u  = '0;
        lin_d  = '0;
        eq_cmp = (q_item.ar == q_item.br) && (q_item.ai == q_item.bi);
        unique case (q_item.cmd)
            cau_pkg::CMD_ADD:
            begin
                lin_t = SW'(q_item.ar) + SW'(q_item.br);
                lin_u = SW'(q_item.ai) + SW'(q_item.bi);
            end
            cau_pkg::CMD_SUB:
            begin
                lin_t = SW'(q_item.ar) - SW'(q_item.br);
                lin_u = SW'(q_item.ai) - SW'(q_item.bi);
            end
            cau_pkg::CMD_RADD:
            begin
                lin_t = SW'(q_item.ar) + SW'(q_item.br);
                lin_u = SW'(q_item.ai);
            end
            cau_pkg::CMD_RSUB:
            begin
                lin_t = SW'(q_item.ar) - SW'(q_item.br);
                lin_u = SW'(q_item.ai);
            end
            cau_pkg::CMD_NEG:
            begin
                lin_t = -SW'(q_item.ar);
                lin_u = -SW'(q_item.ai);
            end
            cau_pkg::CMD_RDIV:
            begin
                lin_t = SW'(q_item.ar);
                lin_u = SW'(q_item.ai);
                lin_d = SW'(q_item.br);
            end
            default:
            begin
                lin_t = '0;
            end
        endcase
    end

    // Stage 2: combine products into real part, imaginary part and divisor.
    logic signed [SW-1:0] c_t, c_u, c_d;
    logic                 c_cmp;
    logic signed [SW-1:0] sum_a, sum_b;
    logic                 s2_valid_reg;
    logic [2:0]           s2_kind_reg;
    logic signed [SW-1:0] s2_t_reg, s2_u_reg, s2_d_reg;
    logic                 s2_cmp_reg;

    always_comb
    begin
        sum_a = SW'(s1_p_reg[0]) + SW'(s1_p_reg[1]);
        sum_b = SW'(s1_p_reg[4]) + SW'(s1_p_reg[5]);
        c_t   = '0;
        c_u   = '0;
        c_d   = '0;
        c_cmp = 1'b0;
        unique case (s1_kind_reg)
            cau_pkg::KIND_LIN:
            begin
                c_t = s1_t_reg;
                c_u = s1_u_reg;
            end
            cau_pkg::KIND_MUL:
            begin
                if (s1_cmd_reg == cau_pkg::CMD_MUL)
                begin
                    c_t = SW'(s1_p_reg[0]) - SW'(s1_p_reg[1]);
                    c_u = SW'(s1_p_reg[2]) + SW'(s1_p_reg[3]);
                end
                else
                begin
                    c_t = SW'(s1_p_reg[0]);
                    c_u = SW'(s1_p_reg[3]);
                end
            end
            cau_pkg::KIND_DIV:
            begin
                if (s1_cmd_reg == cau_pkg::CMD_DIV)
                begin
                    c_t = sum_a;
                    c_u = SW'(s1_p_reg[3]) - SW'(s1_p_reg[2]);
                    c_d = sum_b;
                end
                else
                begin
                    c_t = s1_t_reg;
                    c_u = s1_u_reg;
                    c_d = s1_d_reg;
                end
            end
            cau_pkg::KIND_CMP:
            begin
                priority case (s1_cmd_reg)
                    cau_pkg::CMD_EQ: c_cmp = s1_cmp_reg;
                    cau_pkg::CMD_NE: c_cmp = !s1_cmp_reg;
                    cau_pkg::CMD_LT: c_cmp = (sum_a < sum_b);
                    default:         c_cmp = (sum_a > sum_b);
                endcase
            end
            default:
            begin
                c_cmp = 1'b0;
            end
        endcase
    end

    // Stage 3: division setup, or final value for everything but division.
    logic signed [SW-1:0]  s3_v [2];
    logic [SW-1:0]         s3_mag [2];
    logic [NUM_W-1:0]      s3_num [2];
    logic [NUM_W-NS-1:0]   s3_hi [2];
    logic [DW-1:0]         s3_den;
    cau_pkg::sat_t         s3_cl [2];
    cau_pkg::lane_t        s3_lane [2];
    logic                  s3_ovf [2];
    cau_pkg::tag_t         s3_tag;

    always_comb
    begin
        s3_v[0] = s2_t_reg;
        s3_v[1] = s2_u_reg;
        s3_den  = DW'(s2_d_reg[SW-1] ? -s2_d_reg : s2_d_reg);
        for (int l = 0; l < 2; l++)
        begin
            s3_mag[l]      = s3_v[l][SW-1] ? -s3_v[l] : s3_v[l];
            s3_num[l]      = NUM_W'(s3_mag[l]) << FRAC_BITS;
            s3_hi[l]       = s3_num[l][NUM_W-1:NS];
            s3_ovf[l]      = (NUM_W'(s3_hi[l]) >= NUM_W'(s3_den));
            s3_lane[l].rem = DW'(s3_hi[l]);
            s3_lane[l].quo = '0;
            s3_lane[l].low = s3_num[l][NS-1:0];
            s3_cl[l]       = clamp((s2_kind_reg == cau_pkg::KIND_MUL)
                                   ? (s3_v[l] >>> FRAC_BITS) : s3_v[l]);
        end
        s3_tag.is_div = (s2_kind_reg == cau_pkg::KIND_DIV);
        s3_tag.dz     = s3_tag.is_div && (s3_den == '0);
        s3_tag.cmp    = s2_cmp_reg;
        s3_tag.neg_r  = s2_t_reg[SW-1] ^ s2_d_reg[SW-1];
        s3_tag.neg_i  = s2_u_reg[SW-1] ^ s2_d_reg[SW-1];
        s3_tag.ovf_r  = s3_ovf[0];
        s3_tag.ovf_i  = s3_ovf[1];
        s3_tag.sat    = s3_cl[0].sat || s3_cl[1].sat;
        s3_tag.res_r  = s3_cl[0].val;
        s3_tag.res_i  = s3_cl[1].val;
    end

    // Division stages: stage zero holds the setup, each later stage one bit.
    logic           st_valid_reg [NS+1];
    cau_pkg::tag_t  st_tag_reg   [NS+1];
    logic [DW-1:0]  st_den_reg   [NS+1];
    cau_pkg::lane_t st_lane_reg  [NS+1][2];
    cau_pkg::lane_t st_lane_next [NS][2];

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                st_lane_next[k][l] = div_step(st_lane_reg[k][l], st_den_reg[k]);
            end
        end
    end

    // Final value of the last stage.
    logic signed [SW-1:0] f_q [2];
    logic                 f_neg [2];
    logic                 f_ovf [2];
    cau_pkg::sat_t        f_cl [2];
    cau_pkg::sat_t        f_out [2];
    cau_pkg::tag_t        f_tag;
    logic                 f_sat;

    always_comb
    begin
        f_tag    = st_tag_reg[NS];
        f_neg[0] = f_tag.neg_r;
        f_neg[1] = f_tag.neg_i;
        f_ovf[0] = f_tag.ovf_r;
        f_ovf[1] = f_tag.ovf_i;
        for (int l = 0; l < 2; l++)
        begin
            f_q[l]  = SW'(st_lane_reg[NS][l].quo);
            f_cl[l] = clamp(f_neg[l] ? -f_q[l] : f_q[l]);
            if (f_tag.dz)
            begin
                f_out[l].sat = 1'b0;
                f_out[l].val = '0;
            end
            else if (f_ovf[l])
            begin
                f_out[l].sat = 1'b1;
                f_out[l].val = f_neg[l] ? MIN_V[31:0] : MAX_V[31:0];
            end
            else
            begin
                f_out[l] = f_cl[l];
            end
        end
        f_sat = f_tag.is_div ? (f_out[0].sat || f_out[1].sat) : f_tag.sat;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
            begin
                st_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= q_valid;
            s2_valid_reg    <= s1_valid_reg;
            st_valid_reg[0] <= s2_valid_reg;
            for (int k = 0; k < NS; k++)
            begin
                st_valid_reg[k+1] <= st_valid_reg[k];
            end
            out_valid_reg <= st_valid_reg[NS];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg  <= q_item.cmd;
            s1_kind_reg <= q_item.kind;
            for (int i = 0; i < 6; i++)
            begin
                s1_p_reg[i] <= ma[i] * mb[i];
            end
            s1_t_reg   <= lin_t;
            s1_u_reg   <= lin_u;
            s1_d_reg   <= lin_d;
            s1_cmp_reg <= eq_cmp;

            s2_kind_reg <= s1_kind_reg;
            s2_t_reg    <= c_t;
            s2_u_reg    <= c_u;
            s2_d_reg    <= c_d;
            s2_cmp_reg  <= c_cmp;

            st_tag_reg[0]     <= s3_tag;
            st_den_reg[0]     <= s3_den;
            st_lane_reg[0][0] <= s3_lane[0];
            st_lane_reg[0][1] <= s3_lane[1];
            for (int k = 0; k < NS; k++)
            begin
                st_tag_reg[k+1]     <= st_tag_reg[k];
                st_den_reg[k+1]     <= st_den_reg[k];
                st_lane_reg[k+1][0] <= st_lane_next[k][0];
                st_lane_reg[k+1][1] <= st_lane_next[k][1];
            end

            res_real       <= f_tag.is_div ? f_out[0].val : f_tag.res_r;
            res_imag       <= f_tag.is_div ? f_out[1].val : f_tag.res_i;
            compare_true   <= f_tag.cmp;
            divide_by_zero <= f_tag.dz;
            saturated      <= f_sat;
        end
    end

endmodule

// ----- rtl/complex_arithmetic_unit_top.sv -----
// Complex arithmetic unit: one result word per input word, Q16.16 by default.
// All opcodes share the multiply, combine and setup stages, the 32-step division
// pipeline and the output register. Throughput is one word per cycle while
// the output register is free or read; else it stalls the whole back pipeline.
// Reset (rst_n low, asynchronous) empties the queue and all pipeline valid bits.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
module complex_arithmetic_unit_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         cmd,
    input  logic signed [31:0] a_real,
    input  logic signed [31:0] a_imag,
    input  logic signed [31:0] b_real,
    input  logic signed [31:0] b_imag,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] res_real,
    output logic signed [31:0] res_imag,
    output logic               compare_true,
    output logic               divide_by_zero,
    output logic               saturated
);

    logic           wr;
    cau_pkg::item_t wr_item;
    logic           q_valid;
    logic           q_pop;
    cau_pkg::item_t q_item;

    // Front end classifies incoming words.
    cau_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .push   (push),
        .full   (full),
        .cmd    (cmd),
        .a_real (a_real),
        .a_imag (a_imag),
        .b_real (b_real),
        .b_imag (b_imag),
        .wr     (wr),
        .item   (wr_item)
    );

    // Queue decouples the two ends.
    cau_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .wdata (wr_item),
        .rd    (q_pop),
        .valid (q_valid),
        .rdata (q_item),
        .full  (full)
    );

    // Back end computes and holds the result.
    cau_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .res_real       (res_real),
        .res_imag       (res_imag),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero),
        .saturated      (saturated)
    );

    // A zero divisor yields a zero result without clamping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && divide_by_zero) |-> (res_real == 0 && res_imag == 0 && !saturated))
    else $error("divide by zero result not cleared");

    // A comparison yields zero parts and no other flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && compare_true) |-> (res_real == 0 && res_imag == 0 && !saturated
                                      && !divide_by_zero))
    else $error("comparison result carries data");

    // With the output free, a queued word always enters the back end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && empty) |-> q_pop)
    else $error("back end stalled with a free output");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the complex arithmetic unit top level.
// Depends on cau_pkg and complex_arithmetic_unit_top; predicts each result word
// with exact wide arithmetic and compares it with what the block returns.
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int FB = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [31:0] rr;
        logic signed [31:0] ri;
        logic               cmp;
        logic               dz;
        logic               sat;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [3:0]         cmd;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
    logic               empty;
    logic               pop;
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               compare_true;
    logic               divide_by_zero;
    logic               saturated;

    answer_t answers_due[$];
    int      mismatches;
    int      cycles;
    bit      hold_off;

    complex_arithmetic_unit_top u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
        .empty(empty), .pop(pop), .res_real(res_real), .res_imag(res_imag),
        .compare_true(compare_true), .divide_by_zero(divide_by_zero),
        .saturated(saturated)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Clamp an exact value to the 32-bit signed range.
    function automatic logic signed [31:0] clamp32(input logic signed [191:0] v,
                                                   inout logic sat);
        if (v > 192'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -192'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Division truncating toward zero on exact magnitudes.
    function automatic logic signed [191:0] quot_trunc(input logic signed [191:0] n,
                                                       input logic signed [191:0] d);
        logic [191:0] q;
        q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    // Work out the result word of the arithmetic unit for one input word.
    function automatic answer_t complex_result(input logic [3:0] op,
            input logic signed [31:0] ar32, input logic signed [31:0] ai32,
            input logic signed [31:0] br32, input logic signed [31:0] bi32);
        answer_t ans;
        logic signed [191:0] ar, ai, br, bi, t, u, den;
        logic sat;
        ar = ar32; ai = ai32; br = br32; bi = bi32;
        sat = 1'b0;
        ans = '{rr: 0, ri: 0, cmp: 0, dz: 0, sat: 0};
        case (op)
            cau_pkg::CMD_ADD:
            begin
                ans.rr = clamp32(ar + br, sat);
                ans.ri = clamp32(ai + bi, sat);
            end
            cau_pkg::CMD_SUB:
            begin
                ans.rr = clamp32(ar - br, sat);
                ans.ri = clamp32(ai - bi, sat);
            end
            cau_pkg::CMD_MUL:
            begin
                ans.rr = clamp32((ar * br - ai * bi) >>> FB, sat);
                ans.ri = clamp32((ar * bi + ai * br) >>> FB, sat);
            end
            cau_pkg::CMD_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    ans.dz = 1'b1;
                else
                begin
                    t = (ar * br + ai * bi) <<< FB;
                    u = (ai * br - ar * bi) <<< FB;
                    ans.rr = clamp32(quot_trunc(t, den), sat);
                    ans.ri = clamp32(quot_trunc(u, den), sat);
                end
            end
            cau_pkg::CMD_RADD:
            begin
                ans.rr = clamp32(ar + br, sat);
                ans.ri = ai32;
            end
            cau_pkg::CMD_RSUB:
            begin
                ans.rr = clamp32(ar - br, sat);
                ans.ri = ai32;
            end
            cau_pkg::CMD_RMUL:
            begin
                ans.rr = clamp32((ar * br) >>> FB, sat);
                ans.ri = clamp32((ai * br) >>> FB, sat);
            end
            cau_pkg::CMD_RDIV:
            begin
                if (br == 0)
                    ans.dz = 1'b1;
                else
                begin
                    ans.rr = clamp32(quot_trunc(ar <<< FB, br), sat);
                    ans.ri = clamp32(quot_trunc(ai <<< FB, br), sat);
                end
            end
            cau_pkg::CMD_NEG:
            begin
                ans.rr = clamp32(-ar, sat);
                ans.ri = clamp32(-ai, sat);
            end
            cau_pkg::CMD_EQ: ans.cmp = (ar == br) && (ai == bi);
            cau_pkg::CMD_NE: ans.cmp = !((ar == br) && (ai == bi));
            cau_pkg::CMD_LT: ans.cmp = (ar * ar + ai * ai) < (br * br + bi * bi);
            cau_pkg::CMD_GT: ans.cmp = (ar * ar + ai * ai) > (br * br + bi * bi);
            default: ;
        endcase
        ans.sat = sat;
        return ans;
    endfunction

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input logic [3:0] op, input logic signed [31:0] ar,
                             input logic signed [31:0] ai, input logic signed [31:0] br,
                             input logic signed [31:0] bi);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        cmd    <= op;
        a_real <= ar;
        a_imag <= ai;
        b_real <= br;
        b_imag <= bi;
        do
            @(posedge clk);
        while (full);
        answers_due.push_back(complex_result(op, ar, ai, br, bi));
    endtask

    // Random operand value, weighted towards edge values and small numbers.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    // Extremes, every opcode and the zero divisor cases.
    task automatic test_directed();
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        send_word(cau_pkg::CMD_ADD, mx, mn, mx, mn);
        send_word(cau_pkg::CMD_SUB, mn, mx, mx, mn);
        send_word(cau_pkg::CMD_MUL, mx, mx, mx, mn);
        send_word(cau_pkg::CMD_MUL, 32'sh00018000, 32'sh00020000, 32'shfffe0000,
                  32'sh00010000);
        send_word(cau_pkg::CMD_DIV, 32'sh00010000, 32'sh00010000, 0, 0);
        send_word(cau_pkg::CMD_DIV, mx, mn, 1, 0);
        send_word(cau_pkg::CMD_DIV, 32'sh00030000, 32'sh00010000, 32'sh00010000,
                  32'shffff0000);
        send_word(cau_pkg::CMD_RADD, mx, mn, mx, 32'sh12345678);
        send_word(cau_pkg::CMD_RSUB, mn, mx, mx, 32'sh7fff0000);
        send_word(cau_pkg::CMD_RMUL, mn, mx, mn, 0);
        send_word(cau_pkg::CMD_RDIV, 32'sh00050000, 32'sh00010000, 0, 32'sh00010000);
        send_word(cau_pkg::CMD_RDIV, -32'sh00070000, 32'sh00030000, 32'sh00020000, 0);
        send_word(cau_pkg::CMD_NEG, mn, mx, 0, 0);
        send_word(cau_pkg::CMD_EQ, mx, mn, mx, mn);
        send_word(cau_pkg::CMD_EQ, mx, mn, mx, mx);
        send_word(cau_pkg::CMD_NE, 5, 6, 5, 6);
        send_word(cau_pkg::CMD_NE, 5, 6, 5, 7);
        send_word(cau_pkg::CMD_LT, 3, 4, 4, 3);
        send_word(cau_pkg::CMD_LT, 1, 1, mn, 0);
        send_word(cau_pkg::CMD_GT, mn, mn, mx, mx);
        send_word(4'd13, mx, mn, mx, mn);
        send_word(4'd14, 1, 2, 3, 4);
        send_word(4'd15, -1, -1, -1, -1);
    endtask

    // Random words over all opcodes, including the unused ones.
    task automatic test_random(input int count);
        logic [3:0] op;
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                              : 4'($urandom_range(0, 12));
            send_word(op, pick_value(), pick_value(), pick_value(),
                      ($urandom_range(0, 9) == 0) ? 32'sd0 : pick_value());
        end
    endtask

    // Hold the result side off long enough for the input to stall.
    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(60);
    endtask

    // Result side: a random wait before each word, with a long hold-off when asked.
    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                gap = $urandom_range(0, 4);
                if (gap != 0)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t exp_word;
        if (rst_n && pop && !empty)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: %h %h", res_real, res_imag);
            end
            else
            begin
                exp_word = answers_due.pop_front();
                if (res_real !== exp_word.rr || res_imag !== exp_word.ri ||
                    compare_true !== exp_word.cmp || divide_by_zero !== exp_word.dz ||
                    saturated !== exp_word.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h %h c%b z%b s%b, got %h %h c%b z%b s%b",
                                 exp_word.rr, exp_word.ri, exp_word.cmp, exp_word.dz,
                                 exp_word.sat, res_real, res_imag, compare_true,
                                 divide_by_zero, saturated);
                end
            end
        end
    end

    // Cycle counter guarding against a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        cmd = '0;
        a_real = '0;
        a_imag = '0;
        b_real = '0;
        b_imag = '0;
        mismatches = 0;
        cycles = 0;
        hold_off = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(520);
        push <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
